@@ hw/rtl/swfr_pkg.sv @@
// Package with the shared constants and the result type of the stop-and-wait frame receiver.
`default_nettype none

package swfr_pkg;

  // Link byte codes.
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ADDR_SENDER = 8'h03;
  localparam logic [7:0] CTRL_I0     = 8'h00;
  localparam logic [7:0] CTRL_I1     = 8'h40;
  localparam logic [7:0] CTRL_RR0    = 8'h05;
  localparam logic [7:0] CTRL_RR1    = 8'h85;
  localparam logic [7:0] CTRL_REJ0   = 8'h01;
  localparam logic [7:0] CTRL_REJ1   = 8'h81;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_BCC2_ERR  = 2'd1;
  localparam logic [1:0] VERDICT_TOO_SHORT = 2'd2;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] verdict;
    logic       reply_needed;
    logic [7:0] reply_control;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/swfr_if.sv @@
// Handshake interfaces for the received byte channel and the result channel.
`default_nettype none

interface swfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swfr_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [1:0] verdict;
  logic       reply_needed;
  logic [7:0] reply_control;
  logic [7:0] payload_length;

  modport source (output valid, output kind, output payload_byte, output verdict,
                  output reply_needed, output reply_control, output payload_length,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input verdict,
                  input reply_needed, input reply_control, input payload_length,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/stop_wait_frame_receiver.sv @@
// Stop-and-wait I-frame receiver: frame parser, payload pass-through and verdict output.
//
// Usage: link bytes enter on rx_i, one item per handshake. The block hunts for the
// opening flag, checks address, control byte (expected sequence bit) and header check,
// then passes body bytes on res_o delayed by one byte while XOR-ing them. The closing
// flag yields one verdict item (accepted, BCC2 error or too short), with the reply
// control byte for the first two; acceptance toggles the sequence bit.
// Throughput: one byte per cycle while rx_i is ready. The parser state is updated when a
// byte is accepted, and its result is written to the output register, or to the skid
// entry when the output register holds a result that is not being taken.
// Stalls: the output register is backed by one skid entry. rx_i stays ready while the
// skid entry is free, so one more byte is taken while a result waits; ready drops only
// when both entries hold results.
// Reset: the parser hunts for a flag, the sequence bit is zero and both output
// entries are empty.
`default_nettype none

module stop_wait_frame_receiver #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  swfr_byte_if.sink     rx_i,
  swfr_result_if.source res_o
);

  localparam int CntW = $clog2(MAX_PAYLOAD + 1);
  localparam int LenW = (CntW > 8) ? CntW : 8;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HCHK = 3'd3,
    PH_BODY = 3'd4
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                seq_q, seq_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [7:0]          held_q, held_d;
  logic [7:0]          check_q, check_d;

  logic                out_valid_q, skid_valid_q;
  swfr_pkg::result_t   out_q, skid_q;

  logic                accept;
  logic                push;
  logic                pop;
  swfr_pkg::result_t   res;
  logic [7:0]          ctrl_exp;
  logic [LenW-1:0]     cnt_m1;
  logic [7:0]          plen;
  logic [7:0]          b;

  assign b        = rx_i.rx_byte;
  assign rx_i.ready = !skid_valid_q;
  assign accept   = rx_i.valid && !skid_valid_q;
  assign pop      = out_valid_q && res_o.ready;
  assign ctrl_exp = seq_q ? swfr_pkg::CTRL_I1 : swfr_pkg::CTRL_I0;

  // Length of the payload without the BCC2 byte, saturated to eight bits.
  assign cnt_m1 = LenW'(count_q) - LenW'(1);
  assign plen   = (cnt_m1 > LenW'(255)) ? 8'hFF : cnt_m1[7:0];

  // Per-byte parser step.
  always_comb begin
    phase_d = phase_q;
    seq_d   = seq_q;
    count_d = count_q;
    held_d  = held_q;
    check_d = check_q;
    push    = 1'b0;
    res     = '0;
    case (phase_q)
      PH_ADDR: begin
        if (b == swfr_pkg::ADDR_SENDER) begin
          phase_d = PH_CTRL;
        end else if (b != swfr_pkg::FLAG_BYTE) begin
          phase_d = PH_HUNT;
        end
      end
      PH_CTRL: begin
        phase_d = (b == ctrl_exp) ? PH_HCHK : PH_HUNT;
      end
      PH_HCHK: begin
        if (b == (swfr_pkg::ADDR_SENDER ^ ctrl_exp)) begin
          phase_d = PH_BODY;
          count_d = '0;
          held_d  = '0;
          check_d = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (b == swfr_pkg::FLAG_BYTE) begin
          phase_d  = PH_HUNT;
          push     = 1'b1;
          res.kind = swfr_pkg::KIND_VERDICT;
          if (count_q == '0) begin
            res.verdict = swfr_pkg::VERDICT_TOO_SHORT;
          end else if (held_q == check_q) begin
            seq_d              = !seq_q;
            res.verdict        = swfr_pkg::VERDICT_ACCEPT;
            res.reply_needed   = 1'b1;
            res.reply_control  = seq_q ? swfr_pkg::CTRL_RR0 : swfr_pkg::CTRL_RR1;
            res.payload_length = plen;
          end else begin
            res.verdict        = swfr_pkg::VERDICT_BCC2_ERR;
            res.reply_needed   = 1'b1;
            res.reply_control  = seq_q ? swfr_pkg::CTRL_REJ1 : swfr_pkg::CTRL_REJ0;
            res.payload_length = plen;
          end
        end else if (count_q == '0) begin
          held_d  = b;
          count_d = CntW'(1);
        end else if (count_q < CntW'(MAX_PAYLOAD)) begin
          // Pass the held byte on and keep the new one as a BCC2 candidate.
          push             = 1'b1;
          res.kind         = swfr_pkg::KIND_PAYLOAD;
          res.payload_byte = held_q;
          check_d          = check_q ^ held_q;
          held_d           = b;
          count_d          = count_q + CntW'(1);
        end
      end
      default: begin
        phase_d = (b == swfr_pkg::FLAG_BYTE) ? PH_ADDR : PH_HUNT;
      end
    endcase
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seq_q   <= 1'b0;
      count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      count_q <= count_d;
    end
  end

  // Body data registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      check_q <= '0;
    end else if (accept) begin
      held_q  <= held_d;
      check_q <= check_d;
    end
  end

  // Output register with one skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept && push;
        end
      end else if (accept && push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept && push) begin
      skid_q <= res;
    end
  end

  // Result channel.
  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = out_q.kind;
  assign res_o.payload_byte   = out_q.payload_byte;
  assign res_o.verdict        = out_q.verdict;
  assign res_o.reply_needed   = out_q.reply_needed;
  assign res_o.reply_control  = out_q.reply_control;
  assign res_o.payload_length = out_q.payload_length;

endmodule

`default_nettype wire
